@@ hdl/tep_pkg.sv @@
package tep_pkg;

   // command codes carried in req_tuser
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_TONE_SAMPLES  = 2'd0;
   localparam logic [1:0] CSR_PAUSE_SAMPLES = 2'd1;
   localparam logic [1:0] CSR_ATTENUATION   = 2'd2;
   localparam logic [1:0] CSR_FRAME_SAMPLES = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] TONE_SAMPLES_RESET  = 16'd720;
   localparam logic [15:0] PAUSE_SAMPLES_RESET = 16'd560;
   localparam logic [5:0]  ATTENUATION_RESET   = 6'd8;
   localparam logic [15:0] FRAME_SAMPLES_RESET = 16'd160;

   localparam logic [7:0] CHAR_STAR    = "*";
   localparam logic [7:0] CHAR_HASH    = "#";
   localparam logic [3:0] CODE_STAR    = 4'd10;
   localparam logic [3:0] CODE_HASH    = 4'd11;
   localparam logic [3:0] CODE_UPPER_A = 4'd12;

   typedef enum logic [1:0] {
      PUSH_QUEUED  = 2'd0,
      PUSH_UNKNOWN = 2'd1,
      PUSH_FULL    = 2'd2,
      PUSH_NONE    = 2'd3
   } push_status_type;

   typedef struct packed {
      logic [3:0]  code;
      logic [5:0]  volume;
      logic [15:0] duration;
   } entry_type;

   typedef struct packed {
      logic            frame_valid;
      logic [3:0]      event_code;
      logic [5:0]      volume_field;
      logic [15:0]     event_duration;
      logic            end_bit;
      logic            marker_bit;
      logic [31:0]     timestamp;
      logic            new_stream;
      push_status_type push_status;
   } result_type;

   typedef struct packed {
      logic capture;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_stall;
   } ctrl_status_type;

   typedef struct packed {
      logic       known;
      logic [3:0] code;
   } dial_type;

   function automatic dial_type map_dial(input logic [7:0] c);
      dial_type d;
      d.known = 1'b1;
      d.code  = 4'd0;
      if (c >= "0" && c <= "9") begin
         d.code = 4'(c - "0");
      end else if (c >= "a" && c <= "c") begin
         d.code = 4'd2;
      end else if (c >= "d" && c <= "f") begin
         d.code = 4'd3;
      end else if (c >= "g" && c <= "i") begin
         d.code = 4'd4;
      end else if (c >= "j" && c <= "l") begin
         d.code = 4'd5;
      end else if (c >= "m" && c <= "o") begin
         d.code = 4'd6;
      end else if (c >= "p" && c <= "s") begin
         d.code = 4'd7;
      end else if (c >= "t" && c <= "v") begin
         d.code = 4'd8;
      end else if (c >= "w" && c <= "z") begin
         d.code = 4'd9;
      end else if (c == CHAR_STAR) begin
         d.code = CODE_STAR;
      end else if (c == CHAR_HASH) begin
         d.code = CODE_HASH;
      end else if (c >= "A" && c <= "D") begin
         d.code = CODE_UPPER_A + 4'(c - "A");
      end else begin
         d.known = 1'b0;
      end
      return d;
   endfunction

endpackage

@@ hdl/tep_ctrl.sv @@
module tep_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  tep_pkg::ctrl_status_type status,
   output tep_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.capture = req_tvalid && req_tready;
      cmd.exec    = (state_ff == ST_EXEC) && !status.out_stall;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // hold while the result register is still occupied
            if (cmd.exec) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/tep_datapath.sv @@
module tep_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_command,
   input  logic [7:0]                          req_dial_char,
   input  logic                                csr_we,
   input  logic [tep_pkg::CSR_INDEX_W-1:0]     csr_addr,
   input  logic [tep_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  tep_pkg::ctrl_cmd_type               cmd,
   output tep_pkg::ctrl_status_type            status,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output tep_pkg::result_type                 result
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // configuration
   logic [15:0] tone_ff, pause_ff, frame_ff;
   logic [5:0]  atten_ff;

   // captured item
   logic       cmd_ff;
   logic [7:0] char_ff;

   // queue
   tep_pkg::entry_type mem [QUEUE_DEPTH];
   tep_pkg::entry_type rd_ff;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // tone progress
   logic [17:0] played_ff, played_in;
   logic [31:0] clock_ff, clock_in;
   logic        open_ff, open_in;

   logic                rsp_valid_ff;
   tep_pkg::result_type res_ff, res_in;

   tep_pkg::dial_type dial;
   logic        push_ok, pop;
   logic        full, empty;
   logic [31:0] clk_base;
   logic [17:0] dur18, played_adv, dur_pause;
   logic [15:0] remain, fs_left;
   logic        in_pause, last_frame;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign dial  = tep_pkg::map_dial(char_ff);

   assign status.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign result           = res_ff;

   always_comb begin
      clk_base   = open_ff ? clock_ff : 32'd0;
      dur18      = {2'b00, rd_ff.duration};
      played_adv = played_ff + {2'b00, frame_ff};
      dur_pause  = dur18 + {2'b00, pause_ff};
      in_pause   = (played_ff >= dur18);
      remain     = 16'(dur18 - played_ff);
      last_frame = (remain <= frame_ff);
      fs_left    = frame_ff - remain;

      push_ok  = 1'b0;
      pop      = 1'b0;
      open_in  = open_ff;
      clock_in = clock_ff;
      played_in = played_ff;
      res_in   = '0;

      if (cmd_ff == tep_pkg::CMD_PUSH) begin
         if (!dial.known) begin
            res_in.push_status = tep_pkg::PUSH_UNKNOWN;
         end else if (full) begin
            res_in.push_status = tep_pkg::PUSH_FULL;
         end else begin
            push_ok            = 1'b1;
            res_in.push_status = tep_pkg::PUSH_QUEUED;
         end
      end else begin
         res_in.push_status = tep_pkg::PUSH_NONE;
         if (empty) begin
            open_in = 1'b0;
         end else begin
            open_in                = 1'b1;
            res_in.new_stream      = !open_ff;
            res_in.frame_valid     = 1'b1;
            res_in.event_code      = rd_ff.code;
            res_in.volume_field    = rd_ff.volume;
            res_in.timestamp       = clk_base - {14'd0, played_ff};
            res_in.marker_bit      = (played_ff == '0);
            if (in_pause) begin
               // repeat the end frame through the pause
               res_in.event_duration = rd_ff.duration;
               res_in.end_bit        = 1'b1;
               clock_in              = clk_base + {16'd0, frame_ff};
               played_in             = played_adv;
               pop                   = (played_adv >= dur_pause);
            end else if (last_frame) begin
               res_in.event_duration = rd_ff.duration;
               res_in.end_bit        = 1'b1;
               if (pause_ff <= fs_left) begin
                  clock_in = clk_base + {15'd0, {1'b0, remain} + {1'b0, pause_ff}};
                  pop      = 1'b1;
               end else begin
                  clock_in  = clk_base + {16'd0, frame_ff};
                  played_in = played_adv;
               end
            end else begin
               res_in.event_duration = played_adv[15:0];
               clock_in              = clk_base + {16'd0, frame_ff};
               played_in             = played_adv;
            end
         end
      end

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in   = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         count_in  = count_ff - CW'(1);
         played_in = '0;
      end
      if (push_ok) begin
         tail_in  = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + AW'(1);
         count_in = count_ff + CW'(1);
      end
   end

   // queue memory, registered read at the head
   always_ff @(posedge clock) begin
      if (cmd.exec && push_ok) begin
         mem[tail_ff] <= '{code: dial.code, volume: atten_ff, duration: tone_ff};
      end
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         char_ff <= req_dial_char;
      end
      if (cmd.exec) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff      <= tep_pkg::TONE_SAMPLES_RESET;
         pause_ff     <= tep_pkg::PAUSE_SAMPLES_RESET;
         atten_ff     <= tep_pkg::ATTENUATION_RESET;
         frame_ff     <= tep_pkg::FRAME_SAMPLES_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         played_ff    <= '0;
         clock_ff     <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               tep_pkg::CSR_TONE_SAMPLES:  tone_ff  <= csr_wdata;
               tep_pkg::CSR_PAUSE_SAMPLES: pause_ff <= csr_wdata;
               tep_pkg::CSR_ATTENUATION:   atten_ff <= csr_wdata[5:0];
               tep_pkg::CSR_FRAME_SAMPLES: frame_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            count_ff  <= count_in;
            played_ff <= played_in;
            clock_ff  <= clock_in;
            open_ff   <= open_in;
         end
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd_ff == tep_pkg::CMD_PUSH && full
      |=> count_ff == $past(count_ff) && tail_ff == $past(tail_ff))
      else $error("push to full queue changed the queue");

   a_empty_request: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd_ff == tep_pkg::CMD_FRAME && empty
      |=> rsp_valid_ff && !res_ff.frame_valid && !open_ff)
      else $error("request on empty queue produced a frame");

   a_pop_resets_progress: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && pop |=> played_ff == '0 && count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not restart tone progress");

endmodule

@@ hdl/telephone_event_packetizer.sv @@
// A request beat is captured into the command and character registers, and the
// result beat is offered once the execute state has loaded the result register.
// The two-state sequencer takes no new request until the current one has executed;
// a stalled result keeps it in its execute state until the result register frees up.
// Reset is synchronous, active high: queue empty, stream closed, registers at defaults;
// queue memory contents are not cleared.
module telephone_event_packetizer #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] dial_char
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] event_code, [9:4] volume_field, [25:10] event_duration, [26] end_bit,
   // [27] marker_bit, [59:28] timestamp, [60] new_stream, [63:61] zero
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [0] frame_valid, [2:1] push_status
   input  logic        csr_we,
   input  logic [tep_pkg::CSR_INDEX_W-1:0] csr_addr,
   input  logic [tep_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tep_pkg::ctrl_cmd_type    cmd;
   tep_pkg::ctrl_status_type status;
   tep_pkg::result_type      result;

   tep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tep_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_tuser),
      .req_dial_char (req_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .result        (result)
   );

   assign rsp_tdata = {3'b000, result.new_stream, result.timestamp, result.marker_bit,
                       result.end_bit, result.event_duration, result.volume_field,
                       result.event_code};
   assign rsp_tuser = {result.push_status, result.frame_valid};

endmodule
